// ===== sv/slpd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the short/long press detector: result codes, register
// indexes, level polarity and the configuration bundle. No dependencies.
package slpd_pkg;

  // Field widths fixed by the transaction format
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Reset values of the configuration registers
  localparam logic [MS_W-1:0]   DEBOUNCE_RST = 16'd10;
  localparam logic [MS_W-1:0]   LONG_RST     = 16'd1000;
  localparam logic [MASK_W-1:0] REPEAT_RST   = 8'd0;

  // Switch level that means held down
  localparam logic LEVEL_PRESSED = 1'b0;

  typedef enum logic [1:0] {
    PRESS_NONE  = 2'd0,
    PRESS_SHORT = 2'd1,
    PRESS_LONG  = 2'd2
  } press_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_REPEAT   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [MS_W-1:0]   debounce_ms;
    logic [MS_W-1:0]   long_press_ms;
    logic [MASK_W-1:0] repeat_mask;
  } cfg_t;

endpackage

// ===== sv/slpd_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the press detector: one poll of one switch per transaction.
// Depends on slpd_pkg for field widths.
interface slpd_in_if;
  logic                         valid;
  logic                         ready;
  logic [slpd_pkg::IDX_W-1:0]   switch_index;
  logic                         level;
  logic [slpd_pkg::TIME_W-1:0]  now_ms;
  logic [1:0]                   forced;

  modport source (output valid, switch_index, level, now_ms, forced, input ready);
  modport sink   (input valid, switch_index, level, now_ms, forced, output ready);
endinterface

// ===== sv/slpd_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the press detector: one result per transaction.
// Depends on slpd_pkg for field widths.
interface slpd_out_if;
  logic                       valid;
  logic                       ready;
  logic [slpd_pkg::IDX_W-1:0] switch_id;
  logic [1:0]                 press;

  modport source (output valid, switch_id, press, input ready);
  modport sink   (input valid, switch_id, press, output ready);
endinterface

// ===== sv/slpd_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file of the press detector (write only).
// Depends on slpd_pkg.
module slpd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [slpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slpd_pkg::CFG_W-1:0]      cfg_data,
  output slpd_pkg::cfg_t                  cfg
);

  // Register writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= slpd_pkg::DEBOUNCE_RST;
      cfg.long_press_ms <= slpd_pkg::LONG_RST;
      cfg.repeat_mask   <= slpd_pkg::REPEAT_RST;
    end else if (cfg_we) begin
      case (slpd_pkg::cfg_reg_t'(cfg_index))
        slpd_pkg::REG_DEBOUNCE: cfg.debounce_ms   <= cfg_data;
        slpd_pkg::REG_LONG:     cfg.long_press_ms <= cfg_data;
        slpd_pkg::REG_REPEAT:   cfg.repeat_mask   <= cfg_data[slpd_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/slpd_detect.sv =====
`timescale 1ns / 1ps
// Per-switch state and the press classification for one registered poll.
// Depends on slpd_pkg.
module slpd_detect #(
  parameter int unsigned NUM_SWITCHES = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [slpd_pkg::IDX_W-1:0]     switch_index,
  input  logic                           level,
  input  logic [slpd_pkg::TIME_W-1:0]    now_ms,
  input  logic [1:0]                     forced,
  input  slpd_pkg::cfg_t                 cfg,
  output slpd_pkg::press_t               press
);

  localparam int unsigned SEL_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

  // Per-switch state
  logic [slpd_pkg::TIME_W-1:0] press_start [NUM_SWITCHES];
  logic [NUM_SWITCHES-1:0]     last_level;
  logic [NUM_SWITCHES-1:0]     armed;

  logic [SEL_W-1:0]            sel;
  logic                        in_range;
  logic                        use_detector;
  logic                        rep;
  logic [slpd_pkg::TIME_W-1:0] held;
  logic                        over_debounce;
  logic                        over_long;
  logic                        under_long;
  logic                        cur_last;
  logic                        cur_armed;
  logic                        start_we;
  logic                        armed_next;
  slpd_pkg::press_t            det_press;

  assign in_range     = ({1'b0, switch_index} < (slpd_pkg::IDX_W + 1)'(NUM_SWITCHES));
  assign sel          = SEL_W'(switch_index);
  assign use_detector = in_range && (forced == 2'(slpd_pkg::PRESS_NONE));

  // Repeat bits exist for the first eight switches only
  assign rep = !switch_index[slpd_pkg::IDX_W-1] && cfg.repeat_mask[switch_index[2:0]];

  assign cur_last  = last_level[sel];
  assign cur_armed = armed[sel];
  assign held      = now_ms - press_start[sel];

  assign over_debounce = held > {16'd0, cfg.debounce_ms};
  assign over_long     = held > {16'd0, cfg.long_press_ms};
  assign under_long    = held < {16'd0, cfg.long_press_ms};

  // Classification of one poll
  always_comb begin
    det_press  = slpd_pkg::PRESS_NONE;
    start_we   = 1'b0;
    armed_next = cur_armed;
    if (level == slpd_pkg::LEVEL_PRESSED) begin
      if (cur_last != slpd_pkg::LEVEL_PRESSED) begin
        start_we = 1'b1;
      end else if (over_debounce && rep) begin
        armed_next = 1'b0;
        det_press  = slpd_pkg::PRESS_SHORT;
      end else if (over_long && (cur_armed || rep)) begin
        armed_next = 1'b0;
        det_press  = slpd_pkg::PRESS_LONG;
      end
    end else if (cur_last == slpd_pkg::LEVEL_PRESSED && over_debounce && under_long
                 && cur_armed) begin
      armed_next = 1'b0;
      det_press  = slpd_pkg::PRESS_SHORT;
    end else begin
      armed_next = 1'b1;
    end
  end

  // Result selection: out of range gives none, a force code bypasses state
  always_comb begin
    press = slpd_pkg::PRESS_NONE;
    if (in_range) begin
      case (forced)
        2'(slpd_pkg::PRESS_NONE):  press = det_press;
        2'(slpd_pkg::PRESS_SHORT): press = slpd_pkg::PRESS_SHORT;
        2'(slpd_pkg::PRESS_LONG):  press = slpd_pkg::PRESS_LONG;
        default:                   press = slpd_pkg::PRESS_NONE;
      endcase
    end
  end

  // State update, once per in-range, unforced transaction handed to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= '0;
      armed      <= '0;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        press_start[i] <= '0;
      end
    end else if (step && use_detector) begin
      last_level[sel] <= level;
      armed[sel]      <= armed_next;
      if (start_we) begin
        press_start[sel] <= now_ms;
      end
    end
  end

endmodule

// ===== sv/short_long_press_detector_top.sv =====
`timescale 1ns / 1ps
// Top level of the short/long press detector: input register, detector,
// result register. Depends on slpd_pkg, slpd_in_if, slpd_out_if, slpd_cfg, slpd_detect.
//
//   channel | direction | fields                                 | handshake
//   --------+-----------+----------------------------------------+-----------
//   in      | sink      | switch_index, level, now_ms, forced    | valid/ready
//   out     | source    | switch_id, press                       | valid/ready
//   cfg     | write     | cfg_index, cfg_data                    | cfg_we
//
// A poll lands in the input register, is classified there while the switch
// state is updated, and its result is registered. One transaction per cycle
// is sustained while the output is not stalled; the state read-modify-write of
// one switch completes as its poll is registered, so consecutive polls of the
// same switch follow each other without gaps. A stalled output holds both
// registers and drops in.ready only when both are full. Synchronous reset clears
// the valid flags of both registers and all per-switch state.
module short_long_press_detector_top #(
  parameter int unsigned NUM_SWITCHES = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  slpd_in_if.sink                        in,
  slpd_out_if.source                     out,
  input  logic                           cfg_we,
  input  logic [slpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slpd_pkg::CFG_W-1:0]     cfg_data
);

  slpd_pkg::cfg_t   cfg;
  slpd_pkg::press_t press;

  // Input register
  logic                         in_valid;
  logic [slpd_pkg::IDX_W-1:0]   in_switch;
  logic                         in_level;
  logic [slpd_pkg::TIME_W-1:0]  in_now;
  logic [1:0]                   in_forced;

  // Result register
  logic                         out_valid;
  logic [slpd_pkg::IDX_W-1:0]   out_switch;
  slpd_pkg::press_t             out_press;

  logic out_free;
  logic step;

  assign out_free = !out_valid || out.ready;
  assign step     = in_valid && out_free;
  assign in.ready = !in_valid || out_free;

  slpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slpd_detect #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_detect (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .switch_index (in_switch),
    .level        (in_level),
    .now_ms       (in_now),
    .forced       (in_forced),
    .cfg          (cfg),
    .press        (press)
  );

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in.ready) begin
      in_valid <= in.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      in_switch <= in.switch_index;
      in_level  <= in.level;
      in_now    <= in.now_ms;
      in_forced <= in.forced;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_switch <= in_switch;
      out_press  <= press;
    end
  end

  assign out.valid     = out_valid;
  assign out.switch_id = out_switch;
  assign out.press     = out_press;

endmodule
